### hdl/qau_pkg.sv
// Shared types and codes for the quaternion arithmetic unit.
package qau_pkg;

  // Width of every component field on the ports.
  localparam int COMP_W = 32;
  localparam int OPC_W  = 3;
  localparam int STAT_W = 2;

  // Operation codes; the two codes past inverse produce a zero result.
  typedef enum logic [OPC_W-1:0] {
    OP_ADD  = 3'd0,
    OP_SUB  = 3'd1,
    OP_MUL  = 3'd2,
    OP_CONJ = 3'd3,
    OP_NORM = 3'd4,
    OP_INV  = 3'd5
  } op_t;

  // Status codes.
  localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
  localparam logic [STAT_W-1:0] ST_ZERO_NORM = 2'd1;
  localparam logic [STAT_W-1:0] ST_SAT       = 2'd2;

  // Control that travels with each item down the pipeline.
  typedef struct packed {
    logic valid;
    op_t  op;
  } ctrl_t;

endpackage

### hdl/qau_op_if.sv
// Operand channel: opcode and two quaternions.
interface qau_op_if;
  logic                                valid;
  logic                                ready;
  logic [qau_pkg::OPC_W-1:0]           opcode;
  logic signed [qau_pkg::COMP_W-1:0]   lhs_w;
  logic signed [qau_pkg::COMP_W-1:0]   lhs_x;
  logic signed [qau_pkg::COMP_W-1:0]   lhs_y;
  logic signed [qau_pkg::COMP_W-1:0]   lhs_z;
  logic signed [qau_pkg::COMP_W-1:0]   rhs_w;
  logic signed [qau_pkg::COMP_W-1:0]   rhs_x;
  logic signed [qau_pkg::COMP_W-1:0]   rhs_y;
  logic signed [qau_pkg::COMP_W-1:0]   rhs_z;

  modport source (output valid, opcode, lhs_w, lhs_x, lhs_y, lhs_z,
                  rhs_w, rhs_x, rhs_y, rhs_z, input ready);
  modport sink (input valid, opcode, lhs_w, lhs_x, lhs_y, lhs_z,
                rhs_w, rhs_x, rhs_y, rhs_z, output ready);
endinterface

### hdl/qau_res_if.sv
// Result channel: one quaternion and a status.
interface qau_res_if;
  logic                                valid;
  logic                                ready;
  logic signed [qau_pkg::COMP_W-1:0]   result_w;
  logic signed [qau_pkg::COMP_W-1:0]   result_x;
  logic signed [qau_pkg::COMP_W-1:0]   result_y;
  logic signed [qau_pkg::COMP_W-1:0]   result_z;
  logic [qau_pkg::STAT_W-1:0]          status;

  modport source (output valid, result_w, result_x, result_y, result_z, status,
                  input ready);
  modport sink (input valid, result_w, result_x, result_y, result_z, status,
                output ready);
endinterface

### hdl/qau_front.sv
// Front pipeline: products, sums, saturation and divider/root setup.
module qau_front #(
  parameter int DW = 32,
  parameter int F  = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 en,
  input  qau_pkg::ctrl_t       in_ctrl,
  input  logic signed [DW-1:0] a [4],
  input  logic signed [DW-1:0] b [4],
  output qau_pkg::ctrl_t       out_ctrl,
  output logic signed [DW-1:0] early_res [4],
  output logic                 early_sat,
  output logic [3:0]           cneg,
  output logic [3:0]           ovf,
  output logic                 zero,
  output logic [2*DW:0]        n,
  output logic [2*DW+1:0]      rad,
  output logic [2*DW:0]        rem0 [4],
  output logic [DW:0]          dlow [4]
);
  localparam int PW   = 2 * DW;
  localparam int SW   = 2 * DW + 1;
  localparam int QW   = DW + 1;
  localparam int RW   = 2 * QW;
  localparam int MW   = PW - F;
  localparam int MSW  = MW + 2;
  localparam int DIVW = DW + 2 * F;
  localparam int HW   = DIVW - QW;
  localparam int CW   = (HW > SW) ? HW : SW;

  // Clamp a wide signed value to DW bits; top bit of the result flags a clamp.
  function automatic logic [DW:0] sat_dw(input logic signed [MSW-1:0] v);
    logic hi_ones;
    logic hi_zeros;
    hi_ones  = &v[MSW-1:DW-1];
    hi_zeros = ~|v[MSW-1:DW-1];
    if (hi_ones || hi_zeros) begin
      sat_dw = {1'b0, v[DW-1:0]};
    end else begin
      sat_dw = {1'b1, v[MSW-1], {(DW-1){~v[MSW-1]}}};
    end
  endfunction

  // Stage 1: all multiplications, add/subtract and conjugate.
  qau_pkg::ctrl_t        c1;
  logic signed [DW:0]    as1 [4];
  logic signed [DW:0]    cj1 [4];
  logic signed [PW-1:0]  p1 [4][4];
  logic signed [PW-1:0]  sq1 [4];

  always_ff @(posedge clk) begin
    if (rst) begin
      c1 <= '0;
    end else if (en) begin
      c1 <= in_ctrl;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 4; i++) begin
        if (in_ctrl.op == qau_pkg::OP_SUB) begin
          as1[i] <= (DW+1)'(a[i]) - (DW+1)'(b[i]);
        end else begin
          as1[i] <= (DW+1)'(a[i]) + (DW+1)'(b[i]);
        end
        cj1[i] <= (i == 0) ? (DW+1)'(a[i]) : -(DW+1)'(a[i]);
        sq1[i] <= PW'(a[i]) * PW'(a[i]);
        for (int k = 0; k < 4; k++) begin
          p1[i][k] <= PW'(a[i]) * PW'(b[k]);
        end
      end
    end
  end

  // Stage 2: Hamilton sums, sum of squares, early result select.
  logic signed [MW-1:0]  t [4][4];
  logic signed [MSW-1:0] ms [4];
  logic [DW:0]           sm [4];
  logic [DW:0]           sa [4];
  logic [DW:0]           sc [4];
  logic signed [DW-1:0]  er_nx [4];
  logic                  es_nx;
  logic [SW-1:0]         n_nx;

  always_comb begin
    for (int j = 0; j < 4; j++) begin
      for (int k = 0; k < 4; k++) begin
        t[j][k] = MW'(p1[j][k] >>> F);
      end
    end
    ms[0] = MSW'(t[0][0]) - MSW'(t[1][1]) - MSW'(t[2][2]) - MSW'(t[3][3]);
    ms[1] = MSW'(t[0][1]) + MSW'(t[1][0]) + MSW'(t[2][3]) - MSW'(t[3][2]);
    ms[2] = MSW'(t[0][2]) - MSW'(t[1][3]) + MSW'(t[2][0]) + MSW'(t[3][1]);
    ms[3] = MSW'(t[0][3]) + MSW'(t[1][2]) - MSW'(t[2][1]) + MSW'(t[3][0]);
    n_nx = SW'(unsigned'(sq1[0])) + SW'(unsigned'(sq1[1]))
         + SW'(unsigned'(sq1[2])) + SW'(unsigned'(sq1[3]));
    es_nx = 1'b0;
    for (int i = 0; i < 4; i++) begin
      sm[i] = sat_dw(ms[i]);
      sa[i] = sat_dw(MSW'(as1[i]));
      sc[i] = sat_dw(MSW'(cj1[i]));
      er_nx[i] = '0;
      case (c1.op)
        qau_pkg::OP_ADD, qau_pkg::OP_SUB: begin
          er_nx[i] = sa[i][DW-1:0];
          es_nx    = es_nx | sa[i][DW];
        end
        qau_pkg::OP_MUL: begin
          er_nx[i] = sm[i][DW-1:0];
          es_nx    = es_nx | sm[i][DW];
        end
        qau_pkg::OP_CONJ: begin
          if (i == 0) begin
            er_nx[i] = cj1[i][DW-1:0];
          end else begin
            er_nx[i] = sc[i][DW-1:0];
            es_nx    = es_nx | sc[i][DW];
          end
        end
        default: begin
          er_nx[i] = '0;
        end
      endcase
    end
  end

  qau_pkg::ctrl_t        c2;
  logic signed [DW-1:0]  er2 [4];
  logic                  es2;
  logic [3:0]            cneg2;
  logic [DW-1:0]         m2 [4];
  logic [SW-1:0]         n2;

  always_ff @(posedge clk) begin
    if (rst) begin
      c2 <= '0;
    end else if (en) begin
      c2 <= c1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      er2 <= er_nx;
      es2 <= es_nx;
      n2  <= n_nx;
      for (int i = 0; i < 4; i++) begin
        cneg2[i] <= cj1[i][DW];
        m2[i]    <= cj1[i][DW] ? DW'(-cj1[i]) : DW'(cj1[i]);
      end
    end
  end

  // Stage 3: dividend split, overflow check and root radicand.
  logic [DIVW-1:0] dv [4];
  logic [HW-1:0]   hi [4];

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      dv[i] = DIVW'(m2[i]) << (2 * F);
      hi[i] = dv[i][DIVW-1:QW];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_ctrl <= '0;
    end else if (en) begin
      out_ctrl <= c2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      early_res <= er2;
      early_sat <= es2;
      cneg      <= cneg2;
      zero      <= (n2 == '0);
      n         <= n2;
      rad       <= RW'(n2);
      for (int i = 0; i < 4; i++) begin
        ovf[i]  <= CW'(hi[i]) >= CW'(n2);
        rem0[i] <= SW'(hi[i]);
        dlow[i] <= dv[i][QW-1:0];
      end
    end
  end

endmodule

### hdl/qau_step.sv
// One pipeline stage of the square root and the four restoring dividers.
module qau_step #(
  parameter int DW     = 32,
  parameter int SIDE_W = 138
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               en,
  input  qau_pkg::ctrl_t     in_ctrl,
  input  logic [SIDE_W-1:0]  in_side,
  input  logic [2*DW:0]      in_n,
  input  logic [2*DW+1:0]    in_rad,
  input  logic [DW+2:0]      in_sr,
  input  logic [DW:0]        in_root,
  input  logic [2*DW:0]      in_rem [4],
  input  logic [DW:0]        in_dl [4],
  input  logic [DW:0]        in_q [4],
  output qau_pkg::ctrl_t     out_ctrl,
  output logic [SIDE_W-1:0]  out_side,
  output logic [2*DW:0]      out_n,
  output logic [2*DW+1:0]    out_rad,
  output logic [DW+2:0]      out_sr,
  output logic [DW:0]        out_root,
  output logic [2*DW:0]      out_rem [4],
  output logic [DW:0]        out_dl [4],
  output logic [DW:0]        out_q [4]
);
  localparam int QW  = DW + 1;
  localparam int SW  = 2 * DW + 1;
  localparam int RW  = 2 * QW;
  localparam int SRW = QW + 2;

  // Root digit: bring down two radicand bits and try (root << 2) | 1.
  logic [SRW+1:0] sr2;
  logic [SRW+1:0] trial;
  logic           rge;
  logic [SW:0]    r2 [4];
  logic           dge [4];

  always_comb begin
    sr2   = {in_sr, in_rad[RW-1 -: 2]};
    trial = (SRW+2)'({in_root, 2'b01});
    rge   = sr2 >= trial;
    for (int i = 0; i < 4; i++) begin
      r2[i]  = {in_rem[i], in_dl[i][QW-1]};
      dge[i] = r2[i] >= {1'b0, in_n};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_ctrl <= '0;
    end else if (en) begin
      out_ctrl <= in_ctrl;
    end
  end

  // Quotient digit per divider and the root digit, one bit each.
  always_ff @(posedge clk) begin
    if (en) begin
      out_side <= in_side;
      out_n    <= in_n;
      out_rad  <= in_rad << 2;
      out_sr   <= rge ? SRW'(sr2 - trial) : SRW'(sr2);
      out_root <= {in_root[QW-2:0], rge};
      for (int i = 0; i < 4; i++) begin
        out_rem[i] <= dge[i] ? SW'(r2[i] - {1'b0, in_n}) : SW'(r2[i]);
        out_dl[i]  <= in_dl[i] << 1;
        out_q[i]   <= {in_q[i][QW-2:0], dge[i]};
      end
    end
  end

endmodule

### hdl/qau_back.sv
// Output stage: final saturation, result select and status.
module qau_back #(
  parameter int DW = 32
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                en,
  input  qau_pkg::ctrl_t                      in_ctrl,
  input  logic signed [DW-1:0]                early_res [4],
  input  logic                                early_sat,
  input  logic [3:0]                          cneg,
  input  logic [3:0]                          ovf,
  input  logic                                zero,
  input  logic [DW:0]                         root,
  input  logic [DW:0]                         q [4],
  output logic                                out_valid,
  output logic signed [qau_pkg::COMP_W-1:0]   res [4],
  output logic [qau_pkg::STAT_W-1:0]          status
);
  logic signed [DW-1:0] v [4];
  logic                 s;
  logic                 zn;
  logic                 qs [4];
  logic [DW:0]          qn [4];

  always_comb begin
    s  = 1'b0;
    zn = 1'b0;
    for (int i = 0; i < 4; i++) begin
      v[i]  = '0;
      qn[i] = -q[i];
      // A negative quotient may reach the most negative value.
      if (cneg[i]) begin
        qs[i] = ovf[i] | q[i][DW] | (q[i][DW-1] & (|q[i][DW-2:0]));
      end else begin
        qs[i] = ovf[i] | q[i][DW] | q[i][DW-1];
      end
    end
    case (in_ctrl.op)
      qau_pkg::OP_NORM: begin
        if (root[DW] || root[DW-1]) begin
          s    = 1'b1;
          v[0] = {1'b0, {(DW-1){1'b1}}};
        end else begin
          v[0] = root[DW-1:0];
        end
      end
      qau_pkg::OP_INV: begin
        if (zero) begin
          zn = 1'b1;
        end else begin
          for (int i = 0; i < 4; i++) begin
            if (qs[i]) begin
              s    = 1'b1;
              v[i] = {cneg[i], {(DW-1){~cneg[i]}}};
            end else begin
              v[i] = cneg[i] ? qn[i][DW-1:0] : q[i][DW-1:0];
            end
          end
        end
      end
      default: begin
        v = early_res;
        s = early_sat;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_ctrl.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 4; i++) begin
        res[i] <= qau_pkg::COMP_W'(v[i]);
      end
      if (s) begin
        status <= qau_pkg::ST_SAT;
      end else if (zn) begin
        status <= qau_pkg::ST_ZERO_NORM;
      end else begin
        status <= qau_pkg::ST_OK;
      end
    end
  end

endmodule

### hdl/quaternion_arithmetic_unit.sv
// Quaternion ALU: add, subtract, Hamilton product, conjugate, norm, inverse.
// The pipeline is three front stages, one stage per root and quotient bit,
// and the output register.
// Throughput is one item per cycle; the whole pipeline advances together and
// holds while a finished item waits at the output.
// Reset clears the control registers (valid bit and opcode) only; the pipeline is empty after reset.
module quaternion_arithmetic_unit #(
  parameter int FRAC_BITS  = 16,
  parameter int DATA_WIDTH = 32
) (
  input  logic      clk,
  input  logic      rst,
  qau_op_if.sink    operands,
  qau_res_if.source results
);
  localparam int DW     = DATA_WIDTH;
  localparam int QW     = DW + 1;
  localparam int SW     = 2 * DW + 1;
  localparam int RW     = 2 * QW;
  localparam int SRW    = QW + 2;
  localparam int SIDE_W = 4 * DW + 10;

  // Global advance: move when the output register is empty or being taken.
  logic           en;
  logic           out_valid;
  qau_pkg::ctrl_t in_ctrl;
  logic signed [DW-1:0] a [4];
  logic signed [DW-1:0] b [4];

  assign en              = !out_valid || results.ready;
  assign operands.ready  = en;
  assign in_ctrl.valid   = operands.valid;
  assign in_ctrl.op      = qau_pkg::op_t'(operands.opcode);
  assign a[0] = operands.lhs_w[DW-1:0];
  assign a[1] = operands.lhs_x[DW-1:0];
  assign a[2] = operands.lhs_y[DW-1:0];
  assign a[3] = operands.lhs_z[DW-1:0];
  assign b[0] = operands.rhs_w[DW-1:0];
  assign b[1] = operands.rhs_x[DW-1:0];
  assign b[2] = operands.rhs_y[DW-1:0];
  assign b[3] = operands.rhs_z[DW-1:0];

  // Stage arrays between the bit-serial root/divide stages.
  qau_pkg::ctrl_t    sc    [QW+1];
  logic [SIDE_W-1:0] side  [QW+1];
  logic [SW-1:0]     sn    [QW+1];
  logic [RW-1:0]     srad  [QW+1];
  logic [SRW-1:0]    ssr   [QW+1];
  logic [QW-1:0]     sroot [QW+1];
  logic [SW-1:0]     srem  [QW+1][4];
  logic [QW-1:0]     sdl   [QW+1][4];
  logic [QW-1:0]     sq    [QW+1][4];

  logic signed [DW-1:0] er0 [4];
  logic                 es0;
  logic [3:0]           cneg0;
  logic [3:0]           ovf0;
  logic                 zero0;

  qau_front #(.DW(DW), .F(FRAC_BITS)) u_front (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_ctrl   (in_ctrl),
    .a         (a),
    .b         (b),
    .out_ctrl  (sc[0]),
    .early_res (er0),
    .early_sat (es0),
    .cneg      (cneg0),
    .ovf       (ovf0),
    .zero      (zero0),
    .n         (sn[0]),
    .rad       (srad[0]),
    .rem0      (srem[0]),
    .dlow      (sdl[0])
  );

  assign side[0]  = {er0[3], er0[2], er0[1], er0[0], es0, cneg0, ovf0, zero0};
  assign ssr[0]   = '0;
  assign sroot[0] = '0;
  assign sq[0][0] = '0;
  assign sq[0][1] = '0;
  assign sq[0][2] = '0;
  assign sq[0][3] = '0;

  // One stage per root bit and quotient bit.
  for (genvar k = 0; k < QW; k++) begin : g_step
    qau_step #(.DW(DW), .SIDE_W(SIDE_W)) u_step (
      .clk      (clk),
      .rst      (rst),
      .en       (en),
      .in_ctrl  (sc[k]),
      .in_side  (side[k]),
      .in_n     (sn[k]),
      .in_rad   (srad[k]),
      .in_sr    (ssr[k]),
      .in_root  (sroot[k]),
      .in_rem   (srem[k]),
      .in_dl    (sdl[k]),
      .in_q     (sq[k]),
      .out_ctrl (sc[k+1]),
      .out_side (side[k+1]),
      .out_n    (sn[k+1]),
      .out_rad  (srad[k+1]),
      .out_sr   (ssr[k+1]),
      .out_root (sroot[k+1]),
      .out_rem  (srem[k+1]),
      .out_dl   (sdl[k+1]),
      .out_q    (sq[k+1])
    );
  end

  // Unpack the carried early results.
  logic signed [DW-1:0] erl [4];
  logic                 esl;
  logic [3:0]           cnegl;
  logic [3:0]           ovfl;
  logic                 zerol;

  assign {erl[3], erl[2], erl[1], erl[0], esl, cnegl, ovfl, zerol} = side[QW];

  logic signed [qau_pkg::COMP_W-1:0] res [4];
  logic [qau_pkg::STAT_W-1:0]        stat;

  qau_back #(.DW(DW)) u_back (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_ctrl   (sc[QW]),
    .early_res (erl),
    .early_sat (esl),
    .cneg      (cnegl),
    .ovf       (ovfl),
    .zero      (zerol),
    .root      (sroot[QW]),
    .q         (sq[QW]),
    .out_valid (out_valid),
    .res       (res),
    .status    (stat)
  );

  assign results.valid    = out_valid;
  assign results.result_w = res[0];
  assign results.result_x = res[1];
  assign results.result_y = res[2];
  assign results.result_z = res[3];
  assign results.status   = stat;

endmodule

### tb/tb_quaternion_arithmetic_unit.sv
// Self-checking testbench for the quaternion arithmetic unit.
`timescale 1ns / 100ps
module tb_quaternion_arithmetic_unit;

  typedef struct {
    logic [qau_pkg::OPC_W-1:0]       opc;
    logic [3:0][qau_pkg::COMP_W-1:0] lhs;
    logic [3:0][qau_pkg::COMP_W-1:0] rhs;
  } quat_op_t;

  typedef struct {
    logic [3:0][qau_pkg::COMP_W-1:0] q;
    logic [qau_pkg::STAT_W-1:0]      st;
  } quat_res_t;

  localparam longint MAX32 = 64'sd2147483647;
  localparam longint MIN32 = -64'sd2147483648;
  localparam int      CYCLE_LIMIT = 400000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  qau_op_if  op_ch ();
  qau_res_if res_ch ();

  quat_op_t  pending_ops[$];
  quat_res_t expected_results[$];
  int        send_idle_pct = 0;
  int        recv_idle_pct = 0;
  int        error_count = 0;
  int        cycle_count = 0;

  quaternion_arithmetic_unit dut (
    .clk(clk),
    .rst(rst),
    .operands(op_ch),
    .results(res_ch)
  );

  always #2 clk = ~clk;

  // Clamp a wide value to the component range, flagging saturation.
  function automatic logic [qau_pkg::COMP_W-1:0] clamp32(input longint v, inout bit flag);
    if (v > MAX32) begin
      flag = 1'b1;
      return MAX32[qau_pkg::COMP_W-1:0];
    end
    if (v < MIN32) begin
      flag = 1'b1;
      return MIN32[qau_pkg::COMP_W-1:0];
    end
    return v[qau_pkg::COMP_W-1:0];
  endfunction

  // Floor square root of a 64-bit unsigned value, one bit at a time.
  function automatic longint unsigned floor_sqrt(input longint unsigned n);
    longint unsigned root;
    longint unsigned trial;
    root = 0;
    for (int i = 31; i >= 0; i--) begin
      trial = root | (64'd1 << i);
      if (trial * trial <= n) root = trial;
    end
    return root;
  endfunction

  // Expected result of one operation on two quaternions.
  function automatic quat_res_t quat_compute(input quat_op_t it);
    quat_res_t       res;
    longint          a[4];
    longint          b[4];
    longint          p[4][4];
    longint          c;
    longint          v;
    longint unsigned m;
    longint unsigned quo;
    logic [65:0]     sumsq;
    bit              sat_seen;
    bit              big;
    sat_seen = 1'b0;
    res.q = '0;
    res.st = qau_pkg::ST_OK;
    for (int i = 0; i < 4; i++) begin
      a[i] = longint'($signed(it.lhs[i]));
      b[i] = longint'($signed(it.rhs[i]));
    end
    case (it.opc)
      qau_pkg::OP_ADD, qau_pkg::OP_SUB: begin
        for (int i = 0; i < 4; i++)
          res.q[i] = clamp32(it.opc == qau_pkg::OP_ADD ? a[i] + b[i] : a[i] - b[i],
                             sat_seen);
      end
      qau_pkg::OP_MUL: begin
        for (int j = 0; j < 4; j++)
          for (int k = 0; k < 4; k++)
            p[j][k] = (a[j] * b[k]) >>> 16;
        res.q[0] = clamp32(p[0][0] - p[1][1] - p[2][2] - p[3][3], sat_seen);
        res.q[1] = clamp32(p[0][1] + p[1][0] + p[2][3] - p[3][2], sat_seen);
        res.q[2] = clamp32(p[0][2] - p[1][3] + p[2][0] + p[3][1], sat_seen);
        res.q[3] = clamp32(p[0][3] + p[1][2] - p[2][1] + p[3][0], sat_seen);
      end
      qau_pkg::OP_CONJ: begin
        res.q[0] = it.lhs[0];
        for (int i = 1; i < 4; i++) res.q[i] = clamp32(-a[i], sat_seen);
      end
      qau_pkg::OP_NORM, qau_pkg::OP_INV: begin
        sumsq = '0;
        for (int i = 0; i < 4; i++) begin
          m = (a[i] < 0) ? longint'(-a[i]) : longint'(a[i]);
          sumsq += 66'(m * m);
        end
        big = (sumsq[65:64] != 2'b00);
        if (it.opc == qau_pkg::OP_NORM) begin
          // Beyond 64 bits the root is at least 2^32, which always saturates.
          if (big) res.q[0] = clamp32(64'sd4294967296, sat_seen);
          else res.q[0] = clamp32(longint'(floor_sqrt(sumsq[63:0])), sat_seen);
        end else if (!big && sumsq == 0) begin
          res.st = qau_pkg::ST_ZERO_NORM;
        end else begin
          for (int i = 0; i < 4; i++) begin
            c = (i == 0) ? a[0] : -a[i];
            m = (c < 0) ? longint'(-c) : longint'(c);
            if (big) quo = m >> 32;
            else quo = (m << 32) / sumsq[63:0];
            // Quotients far above range are capped; they saturate anyway.
            if (quo > (64'd1 << 40)) quo = 64'd1 << 40;
            v = longint'(quo);
            res.q[i] = clamp32(c < 0 ? -v : v, sat_seen);
          end
        end
      end
      default: ;
    endcase
    if (sat_seen) res.st = qau_pkg::ST_SAT;
    return res;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("mismatch at cycle %0d: %s", cycle_count, msg);
    error_count++;
  endtask

  // Driver: pops pending items and records the expected result of each accepted one.
  always @(posedge clk) begin
    quat_op_t it;
    if (rst) begin
      op_ch.valid <= 1'b0;
    end else begin
      if (op_ch.valid && op_ch.ready) begin
        it.opc = op_ch.opcode;
        it.lhs = {op_ch.lhs_z, op_ch.lhs_y, op_ch.lhs_x, op_ch.lhs_w};
        it.rhs = {op_ch.rhs_z, op_ch.rhs_y, op_ch.rhs_x, op_ch.rhs_w};
        expected_results.push_back(quat_compute(it));
      end
      if (!op_ch.valid || op_ch.ready) begin
        if (pending_ops.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          it = pending_ops.pop_front();
          op_ch.valid  <= 1'b1;
          op_ch.opcode <= it.opc;
          op_ch.lhs_w  <= it.lhs[0];
          op_ch.lhs_x  <= it.lhs[1];
          op_ch.lhs_y  <= it.lhs[2];
          op_ch.lhs_z  <= it.lhs[3];
          op_ch.rhs_w  <= it.rhs[0];
          op_ch.rhs_x  <= it.rhs[1];
          op_ch.rhs_y  <= it.rhs[2];
          op_ch.rhs_z  <= it.rhs[3];
        end else begin
          op_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: compares each accepted result with the oldest expectation.
  always @(posedge clk) begin
    quat_res_t exp_res;
    cycle_count <= cycle_count + 1;
    if (rst) begin
      res_ch.ready <= 1'b0;
    end else begin
      if (res_ch.valid && res_ch.ready) begin
        if (expected_results.size() == 0) begin
          report_mismatch("result with no item outstanding");
        end else begin
          exp_res = expected_results.pop_front();
          if (res_ch.result_w !== exp_res.q[0])
            report_mismatch($sformatf("w got %h want %h", res_ch.result_w, exp_res.q[0]));
          if (res_ch.result_x !== exp_res.q[1])
            report_mismatch($sformatf("x got %h want %h", res_ch.result_x, exp_res.q[1]));
          if (res_ch.result_y !== exp_res.q[2])
            report_mismatch($sformatf("y got %h want %h", res_ch.result_y, exp_res.q[2]));
          if (res_ch.result_z !== exp_res.q[3])
            report_mismatch($sformatf("z got %h want %h", res_ch.result_z, exp_res.q[3]));
          if (res_ch.status !== exp_res.st)
            report_mismatch($sformatf("status got %0d want %0d", res_ch.status, exp_res.st));
        end
      end
      res_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Watchdog on the total run length.
  always @(posedge clk) begin
    if (cycle_count > CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  function automatic logic [qau_pkg::COMP_W-1:0] rand_comp(input int kind);
    case (kind)
      0: return $urandom();
      1: return $urandom_range(1) ? 32'h7fffffff : 32'h80000000;
      2: return {{14{$urandom_range(1) == 1}}, 18'($urandom())};
      default: return {{22{$urandom_range(1) == 1}}, 10'($urandom())};
    endcase
  endfunction

  task automatic add_op(input logic [qau_pkg::OPC_W-1:0] opc,
                        input logic [3:0][qau_pkg::COMP_W-1:0] l,
                        input logic [3:0][qau_pkg::COMP_W-1:0] r);
    quat_op_t it;
    it.opc = opc;
    it.lhs = l;
    it.rhs = r;
    pending_ops.push_back(it);
  endtask

  task automatic add_random_ops(input int count);
    logic [3:0][qau_pkg::COMP_W-1:0] l;
    logic [3:0][qau_pkg::COMP_W-1:0] r;
    int kind;
    for (int n = 0; n < count; n++) begin
      kind = $urandom_range(9);
      for (int i = 0; i < 4; i++) begin
        // Mostly small and moderate values, so results land in range.
        l[i] = rand_comp(kind < 2 ? 0 : (kind == 2 ? 1 : (kind < 6 ? 2 : 3)));
        r[i] = rand_comp(kind < 2 ? 0 : (kind == 2 ? 1 : (kind < 6 ? 2 : 3)));
        if ($urandom_range(15) == 0) l[i] = '0;
      end
      // Occasionally a zero left-hand quaternion, under any operation code.
      if ($urandom_range(40) == 0) l = '0;
      add_op(3'($urandom_range(7)), l, r);
    end
  endtask

  task automatic wait_drained();
    while (pending_ops.size() > 0 || expected_results.size() > 0 || op_ch.valid)
      @(posedge clk);
  endtask

  // Stimulus sequence and end of run.
  initial begin
    logic [3:0][qau_pkg::COMP_W-1:0] maxq;
    logic [3:0][qau_pkg::COMP_W-1:0] minq;
    logic [3:0][qau_pkg::COMP_W-1:0] oneq;
    logic [3:0][qau_pkg::COMP_W-1:0] zeroq;
    maxq = {4{32'h7fffffff}};
    minq = {4{32'h80000000}};
    oneq = {32'h0, 32'h0, 32'h0, 32'h00010000};
    zeroq = '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Directed: extremes for every operation, zero norm, unused codes.
    send_idle_pct = 25;
    recv_idle_pct = 72;
    for (int o = 0; o < 8; o++) begin
      add_op(3'(o), maxq, minq);
      add_op(3'(o), minq, minq);
    end
    add_op(qau_pkg::OP_INV, zeroq, maxq);
    add_op(qau_pkg::OP_INV, oneq, zeroq);
    add_op(qau_pkg::OP_NORM, zeroq, zeroq);
    add_op(qau_pkg::OP_MUL, oneq, maxq);
    add_op(qau_pkg::OP_INV, {32'h0, 32'h0, 32'h0, 32'h00000001}, zeroq);
    add_op(qau_pkg::OP_CONJ, maxq, zeroq);
    add_random_ops(460);
    wait_drained();

    send_idle_pct = 72;
    recv_idle_pct = 25;
    add_random_ops(460);
    wait_drained();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    add_random_ops(460);
    wait_drained();

    repeat (60) @(posedge clk);
    if (error_count == 0 && expected_results.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

### sim.f
hdl/qau_pkg.sv
hdl/qau_op_if.sv
hdl/qau_res_if.sv
hdl/qau_front.sv
hdl/qau_step.sv
hdl/qau_back.sv
hdl/quaternion_arithmetic_unit.sv
tb/tb_quaternion_arithmetic_unit.sv
